>>> design/assert_macros.svh
// Assertion helpers used by ordered_list_engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define OL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/olist_pkg.sv
package olist_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_LAST  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_LAST  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_SEARCH    = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // What every cell does in one cycle.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_ROT  = 2'd1,
    CELL_INS  = 2'd2,
    CELL_DEL  = 2'd3
  } cell_op_e;

  // Action taken for an accepted command after the checks.
  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_INS  = 3'd1,
    ACT_DEL  = 3'd2,
    ACT_SRCH = 3'd3,
    ACT_CLR  = 3'd4
  } act_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

endpackage

>>> design/olist_cell.sv
module olist_cell #(
  parameter int unsigned PosW = 7,
  parameter int unsigned Idx  = 0
) (
  input  logic                                clk_i,
  input  olist_pkg::cell_op_e                 op_i,
  input  logic [PosW-1:0]                     pos_i,
  input  logic [olist_pkg::DataW-1:0]         value_i,
  input  logic [olist_pkg::DataW-1:0]         left_i,
  input  logic [olist_pkg::DataW-1:0]         right_i,
  output logic [olist_pkg::DataW-1:0]         data_o
);
  import olist_pkg::*;

  localparam logic [PosW-1:0] IdxP = PosW'(Idx);

  logic [DataW-1:0] data_d, data_q;

  // Pick the next entry: hold it, rotate toward the head, open a gap or close one.
  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_ROT: data_d = right_i;
      CELL_INS: begin
        if (IdxP > pos_i) begin
          data_d = left_i;
        end else if (IdxP == pos_i) begin
          data_d = value_i;
        end
      end
      CELL_DEL: begin
        if (IdxP >= pos_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> design/olist_chain.sv
module olist_chain #(
  parameter int unsigned Capacity = 64,
  parameter int unsigned PosW     = 7
) (
  input  logic                          clk_i,
  input  olist_pkg::cell_op_e           op_i,
  input  logic [PosW-1:0]               pos_i,
  input  logic [olist_pkg::DataW-1:0]   value_i,
  output logic [olist_pkg::DataW-1:0]   head_o
);
  import olist_pkg::*;

  logic [DataW-1:0] cell_data [Capacity];

  // Close the row into a ring so a full rotation restores the order.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    olist_cell #(
      .PosW (PosW),
      .Idx  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op_i),
      .pos_i   (pos_i),
      .value_i (value_i),
      .left_i  (cell_data[(i + Capacity - 1) % Capacity]),
      .right_i (cell_data[(i + 1) % Capacity]),
      .data_o  (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

>>> design/ordered_list_engine.sv
// Insert, clear and refused commands go from idle to the commit state; delete
// and search first pass the scan state, which turns the cell ring through one
// full rotation past the head compare. The result word is registered at commit,
// which waits on out_stall_i; no new word is taken until the engine is idle.
// Reset clears the count, the control state and the output valid; entry cells
// are not reset and are read only below the count.
`include "assert_macros.svh"

module ordered_list_engine #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned IdxW = $clog2(CAPACITY),
  localparam int unsigned PosW = $clog2(CAPACITY + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [2:0]                           command_i,
  input  logic signed [olist_pkg::DataW-1:0]   value_i,
  input  logic [PosW-1:0]                      position_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [2:0]                           status_o,
  output logic signed [olist_pkg::DataW-1:0]   removed_value_o,
  output logic [IdxW-1:0]                      found_position_o,
  output logic [PosW-1:0]                      entry_count_o
);
  import olist_pkg::*;

  localparam logic [PosW-1:0] CapP  = PosW'(CAPACITY);
  localparam logic [IdxW-1:0] LastK = IdxW'(CAPACITY - 1);

  state_e           state_d, state_q;
  act_e             act_d, act_q;
  status_e          err_d, err_q;
  logic [PosW-1:0]  count_d, count_q;
  logic [PosW-1:0]  pos_d, pos_q;
  logic [DataW-1:0] val_d, val_q;
  logic [IdxW-1:0]  k_d, k_q;
  logic             hit_d, hit_q;
  logic [IdxW-1:0]  found_d, found_q;
  logic [DataW-1:0] removed_d, removed_q;

  logic             out_valid_d, out_valid_q;
  logic [2:0]       status_d, status_q;
  logic [DataW-1:0] res_removed_d, res_removed_q;
  logic [IdxW-1:0]  res_found_d, res_found_q;
  logic [PosW-1:0]  res_count_d, res_count_q;

  cmd_e             cmd;
  logic             accept;
  logic             fin_go;
  logic             list_full;
  logic             list_empty;
  cell_op_e         chain_op;
  logic [DataW-1:0] head;
  act_e             dec_act;
  status_e          dec_err;
  logic [PosW-1:0]  dec_pos;

  assign cmd        = cmd_e'(command_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign fin_go     = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign list_full  = (count_q == CapP);
  assign list_empty = (count_q == '0);

  // Check the command against the count and settle the target position.
  always_comb begin
    dec_act = ACT_NONE;
    dec_err = ST_OK;
    dec_pos = '0;
    unique case (cmd)
      CMD_INS_FRONT, CMD_INS_LAST, CMD_INS_POS: begin
        if (list_full) begin
          dec_err = ST_FULL;
        end else if (cmd == CMD_INS_FRONT) begin
          dec_act = ACT_INS;
        end else if (cmd == CMD_INS_LAST) begin
          dec_act = ACT_INS;
          dec_pos = count_q;
        end else if (position_i > count_q) begin
          dec_err = ST_BADPOS;
        end else begin
          dec_act = ACT_INS;
          dec_pos = position_i;
        end
      end
      CMD_DEL_FRONT, CMD_DEL_LAST, CMD_DEL_POS: begin
        if (list_empty) begin
          dec_err = ST_EMPTY;
        end else if (cmd == CMD_DEL_FRONT) begin
          dec_act = ACT_DEL;
        end else if (cmd == CMD_DEL_LAST) begin
          dec_act = ACT_DEL;
          dec_pos = count_q - PosW'(1);
        end else if (position_i >= count_q) begin
          dec_err = ST_BADPOS;
        end else begin
          dec_act = ACT_DEL;
          dec_pos = position_i;
        end
      end
      CMD_SEARCH: begin
        if (list_empty) begin
          dec_err = ST_NOTFOUND;
        end else begin
          dec_act = ACT_SRCH;
        end
      end
      CMD_CLEAR: dec_act = ACT_CLR;
      default: dec_act = ACT_NONE;
    endcase
  end

  // Sequence: take a word, rotate the ring once if needed, then commit.
  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    err_d     = err_q;
    pos_d     = pos_q;
    val_d     = val_q;
    k_d       = k_q;
    hit_d     = hit_q;
    found_d   = found_q;
    removed_d = removed_q;
    count_d   = count_q;
    chain_op  = CELL_HOLD;

    out_valid_d   = out_valid_q && out_stall_i;
    status_d      = status_q;
    res_removed_d = res_removed_q;
    res_found_d   = res_found_q;
    res_count_d   = res_count_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d     = dec_act;
          err_d     = dec_err;
          pos_d     = dec_pos;
          val_d     = value_i;
          k_d       = '0;
          hit_d     = 1'b0;
          found_d   = '0;
          removed_d = '0;
          if (dec_act == ACT_DEL || dec_act == ACT_SRCH) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        chain_op = CELL_ROT;
        // Entry k sits at the head in this cycle.
        if (act_q == ACT_SRCH && !hit_q && (PosW'(k_q) < count_q) && (head == val_q)) begin
          hit_d   = 1'b1;
          found_d = k_q;
        end
        if (act_q == ACT_DEL && (PosW'(k_q) == pos_q)) begin
          removed_d = head;
        end
        k_d = k_q + IdxW'(1);
        if (k_q == LastK) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_d       = S_IDLE;
          out_valid_d   = 1'b1;
          status_d      = ST_OK;
          res_removed_d = '0;
          res_found_d   = '0;
          case (act_q)
            ACT_INS: begin
              chain_op = CELL_INS;
              count_d  = count_q + PosW'(1);
            end
            ACT_DEL: begin
              chain_op      = CELL_DEL;
              count_d       = count_q - PosW'(1);
              res_removed_d = removed_q;
            end
            ACT_SRCH: begin
              if (hit_q) begin
                res_found_d = found_q;
              end else begin
                status_d = ST_NOTFOUND;
              end
            end
            ACT_CLR: count_d = '0;
            default: status_d = err_q;
          endcase
          res_count_d = count_d;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  olist_chain #(
    .Capacity (CAPACITY),
    .PosW     (PosW)
  ) u_chain (
    .clk_i   (clk_i),
    .op_i    (chain_op),
    .pos_i   (pos_q),
    .value_i (val_q),
    .head_o  (head)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      act_q       <= ACT_NONE;
      k_q         <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      act_q       <= act_d;
      k_q         <= k_d;
      hit_q       <= hit_d;
    end
  end

  // Payload and result word.
  always_ff @(posedge clk_i) begin
    err_q         <= err_d;
    pos_q         <= pos_d;
    val_q         <= val_d;
    found_q       <= found_d;
    removed_q     <= removed_d;
    status_q      <= status_d;
    res_removed_q <= res_removed_d;
    res_found_q   <= res_found_d;
    res_count_q   <= res_count_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign removed_value_o  = res_removed_q;
  assign found_position_o = res_found_q;
  assign entry_count_o    = res_count_q;

  `OL_ASSERT(a_count_cap, count_q <= CapP, "entry count above capacity")
  `OL_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "accepted word left engine idle")
  `OL_ASSERT_NEXT(a_fin_result, fin_go, out_valid_q, "commit produced no result word")
  `OL_ASSERT(a_scan_act, (state_q != S_SCAN) || act_q == ACT_DEL || act_q == ACT_SRCH, "ring rotation for a command that needs no scan")

endmodule
